// ----- rtl/bmp_dec_pkg.sv -----
// ----------------------------------------------------------------------------
// bmp_dec_pkg
// types and constants shared by the bmp raster decoder front, queue and back
// ----------------------------------------------------------------------------
package bmp_dec_pkg;

  localparam int unsigned CFG_IW      = 2;
  localparam int unsigned CFG_DW      = 13;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IW-1:0] {
    CFG_DEPTH_MODE   = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DEPTH_1BPP  = 2'd0,
    DEPTH_4BPP  = 2'd1,
    DEPTH_8BPP  = 2'd2,
    DEPTH_24BPP = 2'd3
  } depth_e;

  typedef enum logic {
    CMD_PAL_LOAD = 1'b0,
    CMD_RASTER   = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    JOB_PAL_WR,
    JOB_MONO,
    JOB_NIBBLE,
    JOB_INDEX,
    JOB_RGB
  } job_kind_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data_byte;
    logic [7:0] pal_index;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       pixel_red;
    logic [7:0]       pixel_green;
    logic [7:0]       pixel_blue;
    logic [POS_W-1:0] pixel_column;
    logic [POS_W-1:0] pixel_row;
    logic             last_of_item;
    logic             last_of_image;
  } out_item_t;

  // one decoded byte (three gathered bytes in 24 bpp) or palette write, handed from front to back
  typedef struct packed {
    job_kind_e        kind;
    logic [7:0]       idx;
    logic [23:0]      rgb;
    logic [3:0]       cnt;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last_img;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

// ----- rtl/bmp_raster_to_rgb_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// bmp_raster_to_rgb_decoder_unit
// decodes 1, 4, 8 and 24 bpp bmp raster bytes into rgb pixels with position
// ----------------------------------------------------------------------------
// channel  dir  handshake                  payload
// in       in   in_valid_i / in_ready_o    in_item_t (palette load or byte)
// out      out  out_valid_o / out_ready_i  out_item_t (one pixel)
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// the front takes one item a cycle while the four-entry job queue has room
// the back emits one pixel a cycle while out_ready_i allows: a byte gives its pixels
// (up to eight in 1 bpp), a palette load and padding give none
// pixels are registered from the job at the queue head
// no clearing pass after reset: palette entries are undefined until written
// a stalled output holds its pixel while the front keeps filling the queue
// ----------------------------------------------------------------------------
module bmp_raster_to_rgb_decoder_unit #(
  parameter int unsigned MAX_WIDTH     = 4096,
  parameter int unsigned MAX_HEIGHT    = 4096,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bmp_dec_pkg::in_item_t          in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bmp_dec_pkg::out_item_t         out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bmp_dec_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [bmp_dec_pkg::CFG_DW-1:0] cfg_data_i
);
  import bmp_dec_pkg::*;

  queue_status_t q_status;
  job_t          push_job, head_job;
  logic          push, pop;

  bmp_dec_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .job_o       (push_job)
  );

  bmp_dec_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .status_o (q_status),
    .job_o    (head_job)
  );

  bmp_dec_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// ----- rtl/bmp_dec_front.sv -----
// ----------------------------------------------------------------------------
// bmp_dec_front
// accepts items, keeps the raster position and turns pixel data bytes into jobs
// ----------------------------------------------------------------------------
module bmp_dec_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  bmp_dec_pkg::in_item_t                 in_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bmp_dec_pkg::CFG_IW-1:0]        cfg_index_i,
  input  logic [bmp_dec_pkg::CFG_DW-1:0]        cfg_data_i,
  input  bmp_dec_pkg::queue_status_t            q_status_i,
  output logic                                  push_o,
  output bmp_dec_pkg::job_t                     job_o
);
  import bmp_dec_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = WW + 2;

  depth_e          mode_q;
  logic [WW-1:0]   width_q;
  logic [HW-1:0]   height_q;
  logic [WW-1:0]   col_q, col_d;
  logic [HW-1:0]   row_q, row_d;
  logic [RW-1:0]   rbc_q, rbc_d;
  logic [1:0]      phase_q, phase_d;
  logic [15:0]     held_q, held_d;

  logic [WW-1:0]   wr_width;
  logic [HW-1:0]   wr_height;
  logic [RW-1:0]   w_ext, data_len, row_len, rbc_nxt;
  logic [WW-1:0]   col_left, end_col;
  logic [3:0]      cnt;
  logic            accept, in_data, row_end;
  logic [7:0]      b;

  assign in_ready_o  = !q_status_i.full;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign b           = in_i.data_byte;

  // saturate register writes to the supported range
  always_comb begin
    wr_width = WW'(MAX_WIDTH);
    if (cfg_data_i == '0) begin
      wr_width = WW'(1);
    end else if (32'(cfg_data_i) <= MAX_WIDTH) begin
      wr_width = WW'(cfg_data_i);
    end
    wr_height = HW'(MAX_HEIGHT);
    if (cfg_data_i == '0) begin
      wr_height = HW'(1);
    end else if (32'(cfg_data_i) <= MAX_HEIGHT) begin
      wr_height = HW'(cfg_data_i);
    end
  end

  // bytes of pixel data per row, and row length padded to four bytes
  always_comb begin
    w_ext = RW'(width_q);
    unique case (mode_q)
      DEPTH_1BPP:  data_len = (w_ext + RW'(7)) >> 3;
      DEPTH_4BPP:  data_len = (w_ext + RW'(1)) >> 1;
      DEPTH_8BPP:  data_len = w_ext;
      DEPTH_24BPP: data_len = w_ext + (w_ext << 1);
      default:     data_len = w_ext;
    endcase
    row_len = (data_len + RW'(3)) & ~RW'(3);
    rbc_nxt = rbc_q + RW'(1);
    row_end = rbc_nxt >= row_len;
    in_data = rbc_q < data_len;
  end

  always_comb begin
    col_left = width_q - col_q;
    cnt      = 4'd1;
    unique case (mode_q)
      DEPTH_1BPP: cnt = (col_left >= WW'(8)) ? 4'd8 : col_left[3:0];
      DEPTH_4BPP: cnt = (col_left >= WW'(2)) ? 4'd2 : 4'd1;
      default:    cnt = 4'd1;
    endcase
    end_col = col_q + WW'(cnt);
  end

  always_comb begin
    job_o.kind     = JOB_PAL_WR;
    job_o.idx      = in_i.pal_index;
    job_o.rgb      = {in_i.pal_red, in_i.pal_green, in_i.pal_blue};
    job_o.cnt      = cnt;
    job_o.col      = POS_W'(col_q);
    job_o.row      = POS_W'(height_q - HW'(1) - row_q);
    job_o.last_img = (row_q == height_q - HW'(1)) && (end_col >= width_q);
    push_o         = 1'b0;
    col_d          = col_q;
    row_d          = row_q;
    rbc_d          = rbc_q;
    phase_d        = phase_q;
    held_d         = held_q;
    if (accept) begin
      if (in_i.cmd == CMD_PAL_LOAD) begin
        push_o = 1'b1;
      end else begin
        job_o.idx = b;
        job_o.rgb = {b, held_q};
        if (in_data) begin
          unique case (mode_q)
            DEPTH_1BPP: begin
              job_o.kind = JOB_MONO;
              push_o     = 1'b1;
              col_d      = end_col;
            end
            DEPTH_4BPP: begin
              job_o.kind = JOB_NIBBLE;
              push_o     = 1'b1;
              col_d      = end_col;
            end
            DEPTH_8BPP: begin
              job_o.kind = JOB_INDEX;
              push_o     = 1'b1;
              col_d      = end_col;
            end
            default: begin
              job_o.kind = JOB_RGB;
              if (phase_q == 2'd0) begin
                held_d  = {8'd0, b};
                phase_d = 2'd1;
              end else if (phase_q == 2'd1) begin
                held_d  = {b, held_q[7:0]};
                phase_d = 2'd2;
              end else begin
                push_o  = 1'b1;
                col_d   = end_col;
                held_d  = '0;
                phase_d = 2'd0;
              end
            end
          endcase
        end
        rbc_d = rbc_nxt;
        if (row_end) begin
          rbc_d   = '0;
          col_d   = '0;
          phase_d = 2'd0;
          held_d  = '0;
          row_d   = (row_q + HW'(1) >= height_q) ? '0 : row_q + HW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= DEPTH_8BPP;
      width_q  <= WW'(1);
      height_q <= HW'(1);
      col_q    <= '0;
      row_q    <= '0;
      rbc_q    <= '0;
      phase_q  <= 2'd0;
      held_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      // a write to a defined register restarts the image
      case (cfg_index_i)
        CFG_DEPTH_MODE:   mode_q   <= depth_e'(cfg_data_i[1:0]);
        CFG_IMAGE_WIDTH:  width_q  <= wr_width;
        CFG_IMAGE_HEIGHT: height_q <= wr_height;
        default: ;
      endcase
      if (cfg_index_i == CFG_DEPTH_MODE || cfg_index_i == CFG_IMAGE_WIDTH ||
          cfg_index_i == CFG_IMAGE_HEIGHT) begin
        col_q   <= '0;
        row_q   <= '0;
        rbc_q   <= '0;
        phase_q <= 2'd0;
        held_q  <= '0;
      end
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      rbc_q   <= rbc_d;
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// ----- rtl/bmp_dec_queue.sv -----
// ----------------------------------------------------------------------------
// bmp_dec_queue
// small job queue between the front and back parts
// ----------------------------------------------------------------------------
module bmp_dec_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  bmp_dec_pkg::job_t          job_i,
  input  logic                       pop_i,
  output bmp_dec_pkg::queue_status_t status_o,
  output bmp_dec_pkg::job_t          job_o
);
  import bmp_dec_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  job_t          entry_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign status_o.valid = count_q != '0;
  assign status_o.full  = count_q == CW'(QUEUE_DEPTH);
  assign job_o          = entry_q[rd_ptr_q];
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && status_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/bmp_dec_back.sv -----
// ----------------------------------------------------------------------------
// bmp_dec_back
// expands jobs into pixels, one per cycle while the output is not stalled, and holds the palette memory
// ----------------------------------------------------------------------------
module bmp_dec_back #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bmp_dec_pkg::queue_status_t q_status_i,
  input  bmp_dec_pkg::job_t          job_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bmp_dec_pkg::out_item_t     out_o
);
  import bmp_dec_pkg::*;

  localparam int unsigned PAW = $clog2(PALETTE_DEPTH);

  logic [23:0]      pal_mem [PALETTE_DEPTH];
  logic [23:0]      rd_q;
  logic [2:0]       k_q;
  logic             out_valid_q;
  logic             use_pal_q;
  logic [23:0]      rgb_q;
  logic [POS_W-1:0] col_q, row_q;
  logic             last_item_q, last_img_q;

  logic             is_wr, adv, issue, last_k, use_pal, pal_ok, wr_ok;
  logic [7:0]       addr;
  logic [23:0]      rgb;

  assign is_wr  = q_status_i.valid && job_i.kind == JOB_PAL_WR;
  assign adv    = !out_valid_q || out_ready_i;
  assign issue  = q_status_i.valid && job_i.kind != JOB_PAL_WR && adv;
  assign last_k = {1'b0, k_q} == job_i.cnt - 4'd1;
  assign pop_o  = is_wr || (issue && last_k);
  assign wr_ok  = 32'(job_i.idx) < PALETTE_DEPTH;

  always_comb begin
    addr    = job_i.idx;
    rgb     = job_i.rgb;
    use_pal = 1'b0;
    unique case (job_i.kind)
      JOB_MONO:   rgb = {24{job_i.idx[3'd7 - k_q]}};
      JOB_NIBBLE: begin
        addr    = k_q[0] ? {4'd0, job_i.idx[3:0]} : {4'd0, job_i.idx[7:4]};
        use_pal = 1'b1;
      end
      JOB_INDEX:  use_pal = 1'b1;
      default:    rgb = job_i.rgb;
    endcase
    pal_ok = 32'(addr) < PALETTE_DEPTH;
    // index past the palette gives black
    if (use_pal && !pal_ok) begin
      use_pal = 1'b0;
      rgb     = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_wr && wr_ok) begin
      pal_mem[job_i.idx[PAW-1:0]] <= job_i.rgb;
    end
    if (issue && use_pal) begin
      rd_q <= pal_mem[addr[PAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      use_pal_q   <= use_pal;
      rgb_q       <= rgb;
      col_q       <= job_i.col + POS_W'(k_q);
      row_q       <= job_i.row;
      last_item_q <= last_k;
      last_img_q  <= last_k && job_i.last_img;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      if (adv) begin
        out_valid_q <= issue;
      end
      if (issue) begin
        k_q <= last_k ? '0 : k_q + 3'd1;
      end
    end
  end

  always_comb begin
    out_valid_o = out_valid_q;
    {out_o.pixel_red, out_o.pixel_green, out_o.pixel_blue} = use_pal_q ? rd_q : rgb_q;
    out_o.pixel_column  = col_q;
    out_o.pixel_row     = row_q;
    out_o.last_of_item  = last_item_q;
    out_o.last_of_image = last_img_q;
  end

endmodule

// ----- tb/tb_bmp_raster_to_rgb_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_bmp_raster_to_rgb_decoder_unit
// self-checking bench for the bmp raster decoder: drives palette loads and
// raster bytes under several image settings, predicts every pixel in a small
// tracker class and compares each output transaction field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import bmp_dec_pkg::*;

class raster_decode_tracker;
  localparam int unsigned WIDTH_CAP  = 4096;
  localparam int unsigned HEIGHT_CAP = 4096;

  depth_e      depth;
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  logic [23:0] palette [256];
  bit          written [256];
  int unsigned col;
  int unsigned row;
  int unsigned row_bytes;
  int unsigned phase;
  logic [15:0] held;
  out_item_t   pending_pixels [$];
  out_item_t   fresh [$];
  int unsigned mismatch_count;
  int unsigned pixel_count;

  function new();
    depth      = DEPTH_8BPP;
    width_reg  = 13'd1;
    height_reg = 13'd1;
    foreach (written[i]) written[i] = 1'b0;
    mismatch_count = 0;
    pixel_count    = 0;
    clear_position();
  endfunction

  function void clear_position();
    col       = 0;
    row       = 0;
    row_bytes = 0;
    phase     = 0;
    held      = '0;
  endfunction

  function int unsigned cols();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > WIDTH_CAP) w = WIDTH_CAP;
    return w;
  endfunction

  function int unsigned rows();
    int unsigned h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > HEIGHT_CAP) h = HEIGHT_CAP;
    return h;
  endfunction

  function int unsigned data_bytes();
    int unsigned w;
    w = cols();
    case (depth)
      DEPTH_1BPP: return (w + 7) / 8;
      DEPTH_4BPP: return (w + 1) / 2;
      DEPTH_8BPP: return w;
      default:    return 3 * w;
    endcase
  endfunction

  function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    case (idx)
      CFG_DEPTH_MODE:   depth = depth_e'(data[1:0]);
      CFG_IMAGE_WIDTH:  width_reg = data;
      CFG_IMAGE_HEIGHT: height_reg = data;
      default:          return;
    endcase
    clear_position();
  endfunction

  function logic [7:0] any_written(int unsigned span);
    int unsigned start;
    int unsigned j;
    start = $urandom_range(span - 1, 0);
    for (int unsigned i = 0; i < span; i++) begin
      j = (start + i) % span;
      if (written[j]) return 8'(j);
    end
    return 8'h00;
  endfunction

  // keeps palette lookups on entries that were loaded
  function logic [7:0] fix_raster(logic [7:0] b);
    logic [7:0] v;
    v = b;
    if (row_bytes >= data_bytes()) return v;
    if (depth == DEPTH_8BPP && !written[v]) v = any_written(256);
    if (depth == DEPTH_4BPP) begin
      if (!written[v[7:4]]) v[7:4] = 4'(any_written(16));
      if (col + 1 < cols() && !written[v[3:0]]) v[3:0] = 4'(any_written(16));
    end
    return v;
  endfunction

  function void emit(logic [23:0] rgb, int unsigned w, int unsigned h);
    out_item_t px;
    px.pixel_red     = rgb[23:16];
    px.pixel_green   = rgb[15:8];
    px.pixel_blue    = rgb[7:0];
    px.pixel_column  = POS_W'(col);
    px.pixel_row     = POS_W'(h - 1 - row);
    px.last_of_item  = 1'b0;
    col++;
    px.last_of_image = (col >= w && row == h - 1);
    fresh.push_back(px);
  endfunction

  function void absorb_item(in_item_t item);
    int unsigned w;
    int unsigned h;
    int unsigned len;
    logic [7:0]  b;
    out_item_t   last;
    if (item.cmd == CMD_PAL_LOAD) begin
      palette[item.pal_index] = {item.pal_red, item.pal_green, item.pal_blue};
      written[item.pal_index] = 1'b1;
      return;
    end
    w   = cols();
    h   = rows();
    len = data_bytes();
    b   = item.data_byte;
    if (row_bytes < len) begin
      case (depth)
        DEPTH_1BPP: begin
          for (int k = 0; k < 8 && col < w; k++) emit(b[7-k] ? 24'hffffff : 24'h000000, w, h);
        end
        DEPTH_4BPP: begin
          emit(palette[b[7:4]], w, h);
          if (col < w) emit(palette[b[3:0]], w, h);
        end
        DEPTH_8BPP: emit(palette[b], w, h);
        default: begin
          if (phase == 0) begin
            held  = {8'h00, b};
            phase = 1;
          end else if (phase == 1) begin
            held[15:8] = b;
            phase      = 2;
          end else begin
            emit({b, held}, w, h);
            phase = 0;
            held  = '0;
          end
        end
      endcase
    end
    row_bytes++;
    // end of row including padding to a 4-byte boundary
    if (row_bytes >= (len + 3) / 4 * 4) begin
      row_bytes = 0;
      col       = 0;
      phase     = 0;
      held      = '0;
      row++;
      if (row >= h) row = 0;
    end
    if (fresh.size() > 0) begin
      last = fresh.pop_back();
      last.last_of_item = 1'b1;
      fresh.push_back(last);
    end
    foreach (fresh[i]) pending_pixels.push_back(fresh[i]);
    fresh.delete();
  endfunction

  function int unsigned pending();
    return pending_pixels.size();
  endfunction

  task flag_mismatch(string msg);
    mismatch_count++;
    $display("mismatch: %s", msg);
  endtask

  task check_pixel(out_item_t got);
    out_item_t want;
    pixel_count++;
    if (pending_pixels.size() == 0) begin
      flag_mismatch($sformatf("pixel %0d arrived with none expected: %h", pixel_count, got));
      return;
    end
    want = pending_pixels.pop_front();
    if (got.pixel_red !== want.pixel_red || got.pixel_green !== want.pixel_green ||
        got.pixel_blue !== want.pixel_blue || got.pixel_column !== want.pixel_column ||
        got.pixel_row !== want.pixel_row || got.last_of_item !== want.last_of_item ||
        got.last_of_image !== want.last_of_image) begin
      flag_mismatch($sformatf(
        "pixel %0d got %h%h%h c%0d r%0d li %b lm %b want %h%h%h c%0d r%0d li %b lm %b",
        pixel_count, got.pixel_red, got.pixel_green, got.pixel_blue, got.pixel_column,
        got.pixel_row, got.last_of_item, got.last_of_image, want.pixel_red, want.pixel_green,
        want.pixel_blue, want.pixel_column, want.pixel_row, want.last_of_item,
        want.last_of_image));
    end
  endtask
endclass

module tb_bmp_raster_to_rgb_decoder_unit;

  localparam real         CLK_PERIOD    = 10.0;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned MAX_GAP       = 13;
  localparam logic [CFG_IW-1:0] CFG_SPARE_IDX = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  in_item_t          in_i;
  logic              out_valid_o;
  logic              out_ready_i;
  out_item_t         out_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i;
  logic [CFG_DW-1:0] cfg_data_i;

  raster_decode_tracker tracker;
  int unsigned          cycle_count  = 0;
  bit                   send_burst   = 1'b0;
  bit                   hold_request = 1'b0;

  bmp_raster_to_rgb_decoder_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_bmp_raster_to_rgb_decoder_unit NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_pixel(out_o);
  end

  // output side: random back-pressure plus one long hold-off
  initial begin : pixel_sink
    int unsigned gap;
    bit          burst;
    bit          held_off;
    burst       = 1'b0;
    held_off    = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(24, 0) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(MAX_GAP, 0);
      if (!held_off && hold_request) begin
        gap      = LONG_HOLD;
        held_off = 1'b1;
      end
      @(negedge clk_i);
      if (gap > 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_item(input in_item_t item);
    int unsigned gap;
    if ($urandom_range(24, 0) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(MAX_GAP, 0);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_i       = item;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.absorb_item(item);
  endtask

  task automatic send_raster(input logic [7:0] b);
    in_item_t item;
    item.cmd       = CMD_RASTER;
    item.data_byte = b;
    item.pal_index = 8'($urandom);
    item.pal_red   = 8'($urandom);
    item.pal_green = 8'($urandom);
    item.pal_blue  = 8'($urandom);
    send_item(item);
  endtask

  task automatic load_palette(input logic [7:0] idx, input logic [23:0] rgb);
    in_item_t item;
    item.cmd       = CMD_PAL_LOAD;
    item.data_byte = 8'($urandom);
    item.pal_index = idx;
    item.pal_red   = rgb[23:16];
    item.pal_green = rgb[15:8];
    item.pal_blue  = rgb[7:0];
    send_item(item);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(99, 0) < 12) load_palette(8'($urandom), 24'($urandom));
      else send_raster(tracker.fix_raster(8'($urandom)));
    end
  endtask

  // waits until every expected pixel is out and the job queue has drained
  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_image(input depth_e depth, input logic [CFG_DW-1:0] width,
                           input logic [CFG_DW-1:0] height);
    wait_quiet();
    write_reg(CFG_DEPTH_MODE, {11'($urandom), depth});
    write_reg(CFG_IMAGE_WIDTH, width);
    write_reg(CFG_IMAGE_HEIGHT, height);
  endtask

  initial begin
    tracker     = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: 8 bpp, one pixel, one row
    load_palette(8'd0, 24'($urandom));
    load_palette(8'd255, 24'($urandom));
    load_palette(8'd15, 24'($urandom));
    send_raster(8'h00);
    repeat (3) send_raster(8'($urandom));

    // 1 bpp, two rows with a partial last byte
    set_image(DEPTH_1BPP, 13'd10, 13'd2);
    send_raster(8'hff);
    send_raster(8'h00);
    repeat (2) send_raster(8'($urandom));
    send_raster(8'haa);
    send_raster(8'h55);
    repeat (2) send_raster(8'($urandom));

    // 4 bpp, odd width drops the last low nibble
    set_image(DEPTH_4BPP, 13'd3, 13'd1);
    send_raster(8'h0f);
    send_raster(8'hf0);
    repeat (2) send_raster(8'($urandom));

    // 24 bpp, spare register index written mid-pixel must leave the gather intact
    set_image(DEPTH_24BPP, 13'd1, 13'd1);
    send_raster(8'($urandom));
    send_raster(8'($urandom));
    wait_quiet();
    write_reg(CFG_SPARE_IDX, 13'($urandom));
    send_raster(8'($urandom));
    send_raster(8'($urandom));

    // out-of-range sizes and the largest size
    set_image(DEPTH_8BPP, 13'd0, 13'd0);
    send_random(12);
    set_image(DEPTH_1BPP, 13'h1fff, 13'h1fff);
    send_random(10);
    set_image(DEPTH_24BPP, 13'd4096, 13'd4096);
    send_random(10);

    // long output hold-off while bytes keep coming, so the queue fills up
    set_image(DEPTH_1BPP, 13'd64, 13'd2);
    hold_request = 1'b1;
    send_random(20);

    for (int p = 0; p < 13; p++) begin
      set_image(depth_e'(p % 4),
                ($urandom_range(3, 0) == 0) ? 13'($urandom_range(3, 1))
                                            : 13'($urandom_range(20, 4)),
                13'($urandom_range(4, 1)));
      send_random(30);
    end

    wait_quiet();
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("tb_bmp_raster_to_rgb_decoder_unit OK");
    end else begin
      $display("tb_bmp_raster_to_rgb_decoder_unit NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bmp_dec_pkg.sv
rtl/bmp_dec_front.sv
rtl/bmp_dec_queue.sv
rtl/bmp_dec_back.sv
rtl/bmp_raster_to_rgb_decoder_unit.sv
tb/tb_bmp_raster_to_rgb_decoder_unit.sv
